/* sv/rhpc_pkg.sv */
// ============================================================================
// rhpc_pkg: shared constants and types for the rolling hash pattern counter
// Digit sizes for the serial hash lanes and the control bundle sent to them.
// ============================================================================
`default_nettype none

package rhpc_pkg;

    localparam int MAX_PATTERN_DEF = 1024;
    localparam int NUM_BASES_DEF   = 5;

    localparam int HASH_W  = 64;
    localparam int DIG_W   = 8;
    localparam int DIGITS  = HASH_W / DIG_W;
    localparam int DCNT_W  = $clog2(DIGITS);
    localparam int BASE_W  = 3;
    localparam int CNT_W   = 32;

    typedef struct packed {
        logic step;   // process one digit this cycle
        logic first;  // least significant digit of the word
        logic text;   // text byte, otherwise pattern byte
        logic roll;   // window full: remove the leaving byte
        logic mul_pw; // advance the kept power
        logic clear;  // start of a new case
    } t_lane_ctrl;

endpackage

`default_nettype wire

/* sv/rhpc_if.sv */
// ============================================================================
// rhpc_if: item channels of the rolling hash pattern counter
// Valid/ready channels for input bytes and per-text-byte results.
// ============================================================================
`default_nettype none

interface rhpc_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_byte;
    logic       is_last;
    modport source (output valid, req_type, char_byte, is_last, input ready);
    modport sink   (input valid, req_type, char_byte, is_last, output ready);
endinterface

interface rhpc_out_if;
    logic        valid;
    logic        ready;
    logic        match_here;
    logic [31:0] match_count;
    logic        window_full;
    logic        case_done;
    logic        pattern_overflow;
    modport source (output valid, match_here, match_count, window_full, case_done,
                    pattern_overflow, input ready);
    modport sink   (input valid, match_here, match_count, window_full, case_done,
                    pattern_overflow, output ready);
endinterface

`default_nettype wire

/* sv/rolling_hash_pattern_counter_unit.sv */
// Flow: a text byte is accepted and its leaving byte read from the ring, then it
// passes the load state, eight byte-digit steps and the result state; with no pattern
// its result is formed at acceptance. A pattern byte takes the eight digit steps of the
// serial hash lanes, and a dropped pattern byte takes none. A new item is taken only once
// the last is through, and a result held back by the sink holds off the next item.
// Reset (synchronous, active low) empties the pattern and clears all counts.
`default_nettype none

module rolling_hash_pattern_counter_unit #(
    parameter int MAX_PATTERN = rhpc_pkg::MAX_PATTERN_DEF,
    parameter int NUM_BASES   = rhpc_pkg::NUM_BASES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    rhpc_in_if.sink    i_in,
    rhpc_out_if.source o_out
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int DW = rhpc_pkg::DIG_W;
    localparam int CW = rhpc_pkg::DCNT_W;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_OUT} t_state;

    t_state r_state;
    logic [LW-1:0] r_len, r_seen;
    logic [AW-1:0] r_ptr;
    logic [rhpc_pkg::CNT_W-1:0] r_matches;
    logic r_in_text, r_ovf;
    logic r_text, r_last, r_roll, r_mul;
    logic [DW-1:0] r_char, r_leave;
    logic [CW-1:0] r_dcnt;
    logic [DW-1:0] r_ring [MAX_PATTERN];

    rhpc_pkg::t_lane_ctrl lane_ctrl;
    logic [NUM_BASES-1:0] lane_eq;
    logic accept, new_case;
    logic [LW-1:0] eff_len;
    logic hit;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign new_case   = accept && !i_in.req_type && r_in_text;
    assign eff_len    = r_in_text ? '0 : r_len;
    assign hit        = &lane_eq;

    always_comb begin
        lane_ctrl.step   = (r_state == S_RUN);
        lane_ctrl.first  = (r_dcnt == '0);
        lane_ctrl.text   = r_text;
        lane_ctrl.roll   = r_roll;
        lane_ctrl.mul_pw = r_mul;
        lane_ctrl.clear  = new_case;
    end

    for (genvar k = 0; k < NUM_BASES; k++) begin : g_lane
        rhpc_lane #(.BASE(rhpc_pkg::BASE_W'(k + 1))) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (lane_ctrl),
            .i_char (r_char),
            .i_leave(r_leave),
            .o_eq   (lane_eq[k])
        );
    end

    // The leaving byte is read and the new byte written at the same slot.
    always_ff @(posedge i_clk) begin
        if (accept && i_in.req_type) begin
            r_leave       <= r_ring[r_ptr];
            r_ring[r_ptr] <= i_in.char_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_seen      <= '0;
            r_ptr       <= '0;
            r_matches   <= '0;
            r_in_text   <= 1'b0;
            r_ovf       <= 1'b0;
            r_dcnt      <= '0;
            o_out.valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_dcnt <= '0;
                    if (accept) begin
                        r_text <= i_in.req_type;
                        r_char <= i_in.char_byte;
                        r_last <= i_in.is_last;
                        if (!i_in.req_type) begin
                            if (r_in_text) begin
                                r_len     <= '0;
                                r_seen    <= '0;
                                r_ptr     <= '0;
                                r_matches <= '0;
                                r_in_text <= 1'b0;
                                r_ovf     <= 1'b0;
                            end
                            if (eff_len >= LW'(MAX_PATTERN)) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_mul   <= (eff_len != '0);
                                r_roll  <= 1'b0;
                                r_state <= S_RUN;
                            end
                        end else begin
                            r_in_text <= 1'b1;
                            r_roll    <= (r_seen >= r_len);
                            if (r_len == '0) begin
                                o_out.match_here       <= 1'b0;
                                o_out.match_count      <= r_matches;
                                o_out.window_full      <= 1'b0;
                                o_out.case_done        <= i_in.is_last;
                                o_out.pattern_overflow <= r_ovf;
                                o_out.valid            <= 1'b1;
                                r_state                <= S_OUT;
                            end else begin
                                r_state <= S_LOAD;
                            end
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_dcnt <= r_dcnt + CW'(1);
                    if (r_dcnt == CW'(rhpc_pkg::DIGITS - 1)) begin
                        if (!r_text) begin
                            r_len   <= r_len + LW'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr <= ((LW'(r_ptr) + LW'(1)) >= r_len) ? '0 : r_ptr + AW'(1);
                            if (r_seen < r_len) begin
                                r_seen <= r_seen + LW'(1);
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    // Result is formed on entry from the digit loop, then held.
                    if (!o_out.valid) begin
                        o_out.window_full      <= (r_seen >= r_len);
                        o_out.match_here       <= (r_seen >= r_len) && hit;
                        o_out.match_count      <= ((r_seen >= r_len) && hit &&
                                                   (r_matches != '1)) ?
                                                  r_matches + 1'b1 : r_matches;
                        o_out.case_done        <= r_last;
                        o_out.pattern_overflow <= r_ovf;
                        o_out.valid            <= 1'b1;
                        if ((r_seen >= r_len) && hit && (r_matches != '1)) begin
                            r_matches <= r_matches + 1'b1;
                        end
                    end else if (o_out.ready) begin
                        o_out.valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/rhpc_lane.sv */
// ============================================================================
// rhpc_lane: one polynomial hash base, a byte digit per cycle while stepped
// Pattern hash, text hash and kept power rotate through 64-bit shift registers.
// ============================================================================
`default_nettype none

module rhpc_lane #(
    parameter logic [rhpc_pkg::BASE_W-1:0] BASE = 3'd1
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  rhpc_pkg::t_lane_ctrl           i_ctrl,
    input  wire  [rhpc_pkg::DIG_W-1:0]     i_char,
    input  wire  [rhpc_pkg::DIG_W-1:0]     i_leave,
    output logic                           o_eq
);

    localparam int HW = rhpc_pkg::HASH_W;
    localparam int DW = rhpc_pkg::DIG_W;
    localparam int MW = DW + rhpc_pkg::BASE_W;

    logic [HW-1:0] r_ph, r_th, r_pw;
    logic [rhpc_pkg::BASE_W-1:0] r_hc, r_pc, r_tc;
    logic [DW-1:0] r_mc;
    logic          r_bw;

    logic [DW-1:0] hdig, tdig, pdig, c0, d;
    logic [rhpc_pkg::BASE_W-1:0] cin_h, cin_p, cin_t;
    logic [DW-1:0] cin_m;
    logic          cin_b;
    logic [MW-1:0] hmul, pmul, tmul;
    logic [2*DW-1:0] prod;
    logic [DW:0]     diff;

    always_comb begin
        hdig  = r_ph[DW-1:0];
        tdig  = r_th[DW-1:0];
        pdig  = r_pw[DW-1:0];
        cin_h = i_ctrl.first ? '0 : r_hc;
        cin_p = i_ctrl.first ? '0 : r_pc;
        cin_t = i_ctrl.first ? '0 : r_tc;
        cin_m = i_ctrl.first ? '0 : r_mc;
        cin_b = i_ctrl.first ? 1'b0 : r_bw;
        c0    = i_ctrl.first ? i_char : '0;
        hmul  = MW'(hdig) * MW'(BASE) + MW'(cin_h) + MW'(c0);
        pmul  = MW'(pdig) * MW'(BASE) + MW'(cin_p);
        // leaving * power, then subtract from the text hash, borrow carried
        prod  = (2*DW)'(i_leave) * (2*DW)'(pdig) + (2*DW)'(cin_m);
        diff  = {1'b0, tdig} - {1'b0, prod[DW-1:0]} - (DW+1)'(cin_b);
        d     = i_ctrl.roll ? diff[DW-1:0] : tdig;
        tmul  = MW'(d) * MW'(BASE) + MW'(cin_t) + MW'(c0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_ph <= '0;
            r_th <= '0;
            r_pw <= HW'(1);
            o_eq <= 1'b0;
        end else if (i_ctrl.step) begin
            r_hc <= hmul[MW-1:DW];
            r_pc <= pmul[MW-1:DW];
            r_tc <= tmul[MW-1:DW];
            r_mc <= prod[2*DW-1:DW];
            r_bw <= diff[DW];
            if (i_ctrl.text) begin
                r_th <= {tmul[DW-1:0], r_th[HW-1:DW]};
                r_ph <= {hdig, r_ph[HW-1:DW]};
                r_pw <= {pdig, r_pw[HW-1:DW]};
                o_eq <= (i_ctrl.first ? 1'b1 : o_eq) & (tmul[DW-1:0] == hdig);
            end else begin
                r_ph <= {hmul[DW-1:0], r_ph[HW-1:DW]};
                r_pw <= {(i_ctrl.mul_pw ? pmul[DW-1:0] : pdig), r_pw[HW-1:DW]};
                r_th <= {tdig, r_th[HW-1:DW]};
            end
        end
    end

endmodule

`default_nettype wire
